@@ sv/ipp_dec_pkg.sv @@
// Shared types and constants for the IPP attribute stream decoder.
// No dependencies; the decoder top level uses this package by scoped names.
package ipp_dec_pkg;

  // Field length limit: a name or value length at or above this aborts decoding.
  localparam int unsigned MAX_FIELD_BYTES = 256;
  // Number of payload header bytes that are skipped.
  localparam int unsigned HEADER_BYTES    = 8;

  // Width of the remaining-byte counter; lengths that reach it are below MAX_FIELD_BYTES.
  localparam int unsigned LEFT_W = (MAX_FIELD_BYTES > 2) ? $clog2(MAX_FIELD_BYTES) : 1;

  // Tag codes
  localparam logic [7:0] TAG_END       = 8'h03;
  localparam logic [7:0] TAG_GROUP_LO  = 8'h01;
  localparam logic [7:0] TAG_GROUP_HI  = 8'h05;

  // Result kinds
  localparam logic [2:0] KIND_NAME    = 3'd0;
  localparam logic [2:0] KIND_VALUE   = 3'd1;
  localparam logic [2:0] KIND_NONAME  = 3'd2;
  localparam logic [2:0] KIND_ENDTAG  = 3'd3;
  localparam logic [2:0] KIND_ABORT   = 3'd4;
  localparam logic [2:0] KIND_ENDED   = 3'd5;
  localparam logic [2:0] KIND_NOVALUE = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] value_tag;
    logic       attr_last;
    logic       stream_end;
  } out_beat_t;

endpackage

@@ sv/ipp_attribute_stream_decoder_top.sv @@
// IPP attribute stream decoder: a byte-wide parser state machine with a
// registered result stage and a one-entry skid register. Uses ipp_dec_pkg.
//
// The decoder takes one payload byte per cycle while in_stall is low and
// gives at most one result beat per byte, registered in the output register
// or in the skid register. The parser state is updated by a single small
// step per byte, and the output register plus one skid register let input
// flow continue while a result waits. in_stall rises only when the skid
// register holds a beat, that is after the output side has stalled with a
// beat already waiting. After a byte flagged last_byte the parser returns
// to its reset state, so the next byte starts a new payload.
module ipp_attribute_stream_decoder_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ipp_dec_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ipp_dec_pkg::out_beat_t out_data
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_TAG, PH_NLEN_H, PH_NLEN_L, PH_NAME,
    PH_VLEN_H, PH_VLEN_L, PH_VALUE, PH_DONE
  } phase_t;

  localparam phase_t PH_RESET = (ipp_dec_pkg::HEADER_BYTES == 0) ? PH_TAG : PH_HEADER;

  phase_t                          phase_r, phase_nxt;
  logic [2:0]                      hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]                      len_high_r, len_high_nxt;
  logic [ipp_dec_pkg::LEFT_W-1:0]  left_r, left_nxt;
  logic [7:0]                      cur_tag_r, cur_tag_nxt;

  ipp_dec_pkg::out_beat_t out_r, skid_r, res;
  logic                   out_valid_r, skid_valid_r;

  logic        acc, out_take, emit, open;
  logic [7:0]  b;
  logic        last;
  logic [15:0] len;
  logic        too_big;
  logic [ipp_dec_pkg::LEFT_W-1:0] left_dec;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign acc       = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  assign b        = in_data.data_byte;
  assign last     = in_data.last_byte;
  assign len      = {len_high_r, b};
  assign too_big  = {1'b0, len} >= 17'(ipp_dec_pkg::MAX_FIELD_BYTES);
  assign left_dec = left_r - 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    len_high_nxt = len_high_r;
    left_nxt     = left_r;
    cur_tag_nxt  = cur_tag_r;
    emit         = 1'b0;
    open         = 1'b0;
    res          = '0;
    res.stream_end = last;

    unique case (phase_r)
      PH_HEADER: begin
        if ({1'b0, hdr_cnt_r} + 4'd1 >= 4'(ipp_dec_pkg::HEADER_BYTES)) begin
          phase_nxt = PH_TAG;
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        end
        if (last) begin
          emit     = 1'b1;
          res.kind = ipp_dec_pkg::KIND_ENDED;
        end
      end
      PH_TAG: begin
        if (b == ipp_dec_pkg::TAG_END) begin
          emit      = 1'b1;
          res.kind  = ipp_dec_pkg::KIND_ENDTAG;
          phase_nxt = PH_DONE;
        end else if (b >= ipp_dec_pkg::TAG_GROUP_LO && b <= ipp_dec_pkg::TAG_GROUP_HI) begin
          if (last) begin
            emit     = 1'b1;
            res.kind = ipp_dec_pkg::KIND_ENDED;
          end
        end else begin
          cur_tag_nxt = b;
          phase_nxt   = PH_NLEN_H;
          open        = 1'b1;
        end
      end
      PH_NLEN_H, PH_VLEN_H: begin
        len_high_nxt = b;
        phase_nxt    = (phase_r == PH_NLEN_H) ? PH_NLEN_L : PH_VLEN_L;
        open         = 1'b1;
      end
      PH_NLEN_L, PH_VLEN_L: begin
        res.value_tag = cur_tag_r;
        if (too_big) begin
          emit          = 1'b1;
          res.kind      = ipp_dec_pkg::KIND_ABORT;
          res.attr_last = 1'b1;
          phase_nxt     = PH_DONE;
        end else if (len == 16'd0) begin
          emit = 1'b1;
          if (phase_r == PH_NLEN_L) begin
            res.kind  = ipp_dec_pkg::KIND_NONAME;
            phase_nxt = PH_VLEN_H;
            open      = 1'b1;
          end else begin
            res.kind      = ipp_dec_pkg::KIND_NOVALUE;
            res.attr_last = 1'b1;
            phase_nxt     = PH_TAG;
          end
        end else begin
          left_nxt  = len[ipp_dec_pkg::LEFT_W-1:0];
          phase_nxt = (phase_r == PH_NLEN_L) ? PH_NAME : PH_VALUE;
          open      = 1'b1;
        end
      end
      PH_NAME: begin
        emit          = 1'b1;
        res.kind      = ipp_dec_pkg::KIND_NAME;
        res.out_byte  = b;
        res.value_tag = cur_tag_r;
        left_nxt      = left_dec;
        if (left_dec == '0) phase_nxt = PH_VLEN_H;
        open          = 1'b1;
      end
      PH_VALUE: begin
        emit          = 1'b1;
        res.kind      = ipp_dec_pkg::KIND_VALUE;
        res.out_byte  = b;
        res.value_tag = cur_tag_r;
        left_nxt      = left_dec;
        if (left_dec == '0) begin
          res.attr_last = 1'b1;
          phase_nxt     = PH_TAG;
        end else begin
          open = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // An attribute cut short by the end of the payload reports an abort instead.
    if (last && open) begin
      emit          = 1'b1;
      res.kind      = ipp_dec_pkg::KIND_ABORT;
      res.out_byte  = 8'd0;
      res.value_tag = cur_tag_r;
      res.attr_last = 1'b1;
    end

    if (last) begin
      phase_nxt    = PH_RESET;
      hdr_cnt_nxt  = '0;
      len_high_nxt = '0;
      left_nxt     = '0;
      cur_tag_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RESET;
      hdr_cnt_r    <= '0;
      len_high_r   <= '0;
      left_r       <= '0;
      cur_tag_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        phase_r    <= phase_nxt;
        hdr_cnt_r  <= hdr_cnt_nxt;
        len_high_r <= len_high_nxt;
        left_r     <= left_nxt;
        cur_tag_r  <= cur_tag_nxt;
      end
      if (skid_valid_r) begin
        // Input is stalled here; drain the skid beat into the output register.
        if (out_take) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (acc && emit) begin
        if (!out_valid_r || out_take) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The skid register only fills behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held without an output beat");

  // A last byte always returns the parser to its start state.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last |=> phase_r == PH_RESET && left_r == '0)
    else $error("parser not reset after last byte");

  // A stalled output with a waiting skid beat must not lose it.
  a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_stall |=> skid_valid_r && out_valid_r)
    else $error("skid beat dropped while output stalled");

  // attr_last marks only value, empty-value or abort results.
  a_attr_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.attr_last |->
      (out_r.kind == ipp_dec_pkg::KIND_VALUE || out_r.kind == ipp_dec_pkg::KIND_NOVALUE ||
       out_r.kind == ipp_dec_pkg::KIND_ABORT))
    else $error("attr_last on a result kind that cannot close an attribute");

endmodule

@@ tb/ipp_attribute_stream_decoder_top_tb.sv @@
// Self-checking testbench for ipp_attribute_stream_decoder_top: random IPP payloads,
// bursty input, a stalling receiver and a cycle-free model of the decoder.
// Depends on ipp_dec_pkg and the decoder top level only.
module ipp_attribute_stream_decoder_top_tb;

  typedef enum logic [3:0] {
    ST_HEADER, ST_TAG, ST_NAME_LEN_HI, ST_NAME_LEN_LO, ST_NAME,
    ST_VALUE_LEN_HI, ST_VALUE_LEN_LO, ST_VALUE, ST_DONE
  } parse_state_t;

  localparam int unsigned TARGET_BEATS = 1200;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  ipp_dec_pkg::in_beat_t  in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  ipp_dec_pkg::out_beat_t out_data;

  ipp_attribute_stream_decoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Beats still to be sent, and the decoded beats the block still owes us.
  ipp_dec_pkg::in_beat_t  payload_beats[$];
  ipp_dec_pkg::out_beat_t decoded_beats[$];

  // Decoder model state.
  parse_state_t dec_phase;
  int unsigned  hdr_count;
  logic [7:0]   len_hi;
  logic [15:0]  field_left;
  logic [7:0]   attr_tag;

  int unsigned errors = 0;
  int unsigned payload_count = 0;
  int unsigned beats_total = 0;
  int unsigned beats_taken = 0;
  int unsigned results_seen = 0;
  int unsigned aborts_seen = 0;
  int unsigned endtags_seen = 0;
  int unsigned ended_seen = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void reset_decoder();
    dec_phase  = (ipp_dec_pkg::HEADER_BYTES == 0) ? ST_TAG : ST_HEADER;
    hdr_count  = 0;
    len_hi     = '0;
    field_left = '0;
    attr_tag   = '0;
  endfunction

  function automatic void decode_byte(ipp_dec_pkg::in_beat_t beat);
    logic [7:0]             b;
    logic                   last;
    logic                   emit;
    logic                   open;
    logic [15:0]            len;
    ipp_dec_pkg::out_beat_t res;
    b    = beat.data_byte;
    last = beat.last_byte;
    emit = 1'b0;
    open = 1'b0;
    res  = '0;
    case (dec_phase)
      ST_HEADER: begin
        if (hdr_count + 1 >= ipp_dec_pkg::HEADER_BYTES) dec_phase = ST_TAG;
        else hdr_count = hdr_count + 1;
        if (last) begin
          emit = 1'b1;
          res.kind = ipp_dec_pkg::KIND_ENDED;
        end
      end
      ST_TAG: begin
        if (b == ipp_dec_pkg::TAG_END) begin
          emit = 1'b1;
          res.kind = ipp_dec_pkg::KIND_ENDTAG;
          dec_phase = ST_DONE;
        end else if (b >= ipp_dec_pkg::TAG_GROUP_LO && b <= ipp_dec_pkg::TAG_GROUP_HI) begin
          if (last) begin
            emit = 1'b1;
            res.kind = ipp_dec_pkg::KIND_ENDED;
          end
        end else begin
          attr_tag = b;
          dec_phase = ST_NAME_LEN_HI;
          open = 1'b1;
        end
      end
      ST_NAME_LEN_HI, ST_VALUE_LEN_HI: begin
        len_hi = b;
        dec_phase = (dec_phase == ST_NAME_LEN_HI) ? ST_NAME_LEN_LO : ST_VALUE_LEN_LO;
        open = 1'b1;
      end
      ST_NAME_LEN_LO, ST_VALUE_LEN_LO: begin
        len = {len_hi, b};
        res.value_tag = attr_tag;
        if (len >= ipp_dec_pkg::MAX_FIELD_BYTES) begin
          emit = 1'b1;
          res.kind = ipp_dec_pkg::KIND_ABORT;
          res.attr_last = 1'b1;
          dec_phase = ST_DONE;
        end else if (len == 0) begin
          emit = 1'b1;
          if (dec_phase == ST_NAME_LEN_LO) begin
            res.kind = ipp_dec_pkg::KIND_NONAME;
            dec_phase = ST_VALUE_LEN_HI;
            open = 1'b1;
          end else begin
            res.kind = ipp_dec_pkg::KIND_NOVALUE;
            res.attr_last = 1'b1;
            dec_phase = ST_TAG;
          end
        end else begin
          field_left = len;
          dec_phase = (dec_phase == ST_NAME_LEN_LO) ? ST_NAME : ST_VALUE;
          open = 1'b1;
        end
      end
      ST_NAME: begin
        emit = 1'b1;
        res.kind = ipp_dec_pkg::KIND_NAME;
        res.out_byte = b;
        res.value_tag = attr_tag;
        field_left = field_left - 16'd1;
        if (field_left == 0) dec_phase = ST_VALUE_LEN_HI;
        open = 1'b1;
      end
      ST_VALUE: begin
        emit = 1'b1;
        res.kind = ipp_dec_pkg::KIND_VALUE;
        res.out_byte = b;
        res.value_tag = attr_tag;
        field_left = field_left - 16'd1;
        if (field_left == 0) begin
          res.attr_last = 1'b1;
          dec_phase = ST_TAG;
        end else begin
          open = 1'b1;
        end
      end
      default: dec_phase = ST_DONE;
    endcase

    // A payload that ends inside an attribute turns this beat into an abort.
    if (last && open) begin
      emit = 1'b1;
      res.kind = ipp_dec_pkg::KIND_ABORT;
      res.out_byte = '0;
      res.value_tag = attr_tag;
      res.attr_last = 1'b1;
    end
    if (last) reset_decoder();
    if (emit) begin
      res.stream_end = last;
      decoded_beats.push_back(res);
    end
  endfunction

  // Field lengths: mostly short, with the legal maximum and oversize lengths now and then.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 91) return $urandom_range(1, 6);
    if (r < 93) return ipp_dec_pkg::MAX_FIELD_BYTES - 1;
    if (ipp_dec_pkg::MAX_FIELD_BYTES > 16'hFFFF) return $urandom_range(1, 6);
    if (r < 96) return ipp_dec_pkg::MAX_FIELD_BYTES;
    return $urandom_range(ipp_dec_pkg::MAX_FIELD_BYTES, 16'hFFFF);
  endfunction

  function automatic logic [7:0] pick_group_tag();
    logic [7:0] t;
    do t = 8'($urandom_range(ipp_dec_pkg::TAG_GROUP_LO, ipp_dec_pkg::TAG_GROUP_HI));
    while (t == ipp_dec_pkg::TAG_END);
    return t;
  endfunction

  // Appends one attribute; returns 1 when an oversize length stops the decoder.
  function automatic bit add_attribute(ref logic [7:0] pl[$]);
    logic [7:0]  tag;
    int unsigned len;
    do tag = 8'($urandom_range(0, 255));
    while (tag >= ipp_dec_pkg::TAG_GROUP_LO && tag <= ipp_dec_pkg::TAG_GROUP_HI);
    pl.push_back(tag);
    for (int f = 0; f < 2; f++) begin
      len = pick_len();
      pl.push_back(len[15:8]);
      pl.push_back(len[7:0]);
      if (len >= ipp_dec_pkg::MAX_FIELD_BYTES) return 1'b1;
      repeat (len) pl.push_back(8'($urandom_range(0, 255)));
    end
    return 1'b0;
  endfunction

  function automatic void queue_payload(ref logic [7:0] pl[$]);
    for (int i = 0; i < pl.size(); i++)
      payload_beats.push_back('{data_byte: pl[i], last_byte: (i == pl.size() - 1)});
    payload_count++;
  endfunction

  function automatic void add_random_payload();
    logic [7:0]  pl[$];
    int unsigned mode;
    int unsigned n_attr;
    bit          dead;
    mode = $urandom_range(0, 9);
    dead = 1'b0;
    if (mode < 2) begin
      // Noise: arbitrary bytes with no structure.
      repeat ($urandom_range(1, 14)) pl.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (ipp_dec_pkg::HEADER_BYTES) pl.push_back(8'($urandom_range(0, 255)));
      n_attr = $urandom_range(0, 4);
      for (int i = 0; i < n_attr && !dead; i++) begin
        if ($urandom_range(0, 3) == 0) pl.push_back(pick_group_tag());
        dead = add_attribute(pl);
      end
      if (dead) begin
        repeat ($urandom_range(0, 2)) pl.push_back(8'($urandom_range(0, 255)));
      end else if (mode < 6) begin
        pl.push_back(ipp_dec_pkg::TAG_END);
        repeat ($urandom_range(0, 3)) pl.push_back(8'($urandom_range(0, 255)));
      end else if (mode < 8) begin
        if ($urandom_range(0, 1)) pl.push_back(pick_group_tag());
      end else if (pl.size() > 1) begin
        // Cut the payload short at a random point.
        pl = pl[0 : $urandom_range(0, pl.size() - 1)];
      end
    end
    if (pl.size() == 0) pl.push_back(8'($urandom_range(0, 255)));
    queue_payload(pl);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
      reset_decoder();
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || payload_beats.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_data <= payload_beats.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left = $urandom_range(60, 200);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 30);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
          end
        end
      end
    end
  end

  // Receiver: the stall pattern changes at random; two long holds fill the block up.
  int unsigned stall_mode;
  int unsigned mode_cycles;
  int unsigned hold_left;
  int unsigned holds_done;
  logic        toggle;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      mode_cycles = 0;
      hold_left = 0;
      holds_done = 0;
      toggle = 1'b0;
    end else begin
      if (hold_left == 0 && holds_done < 2 && beats_taken >= 400 + 500 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_cycles = 50;
      end
      mode_cycles--;
      toggle = ~toggle;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= toggle;
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    ipp_dec_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.kind == ipp_dec_pkg::KIND_ABORT) aborts_seen++;
      if (out_data.kind == ipp_dec_pkg::KIND_ENDTAG) endtags_seen++;
      if (out_data.kind == ipp_dec_pkg::KIND_ENDED) ended_seen++;
      if (decoded_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat kind=%0d byte=%h tag=%h attr_last=%b end=%b",
                 $time, out_data.kind, out_data.out_byte, out_data.value_tag,
                 out_data.attr_last, out_data.stream_end);
      end else begin
        want = decoded_beats.pop_front();
        if (out_data.kind !== want.kind || out_data.out_byte !== want.out_byte ||
            out_data.value_tag !== want.value_tag || out_data.attr_last !== want.attr_last ||
            out_data.stream_end !== want.stream_end) begin
          errors++;
          $display("%0t: expected kind=%0d byte=%h tag=%h attr_last=%b end=%b", $time,
                   want.kind, want.out_byte, want.value_tag, want.attr_last, want.stream_end);
          $display("%0t:   actual kind=%0d byte=%h tag=%h attr_last=%b end=%b", $time,
                   out_data.kind, out_data.out_byte, out_data.value_tag,
                   out_data.attr_last, out_data.stream_end);
        end
      end
    end
  end

  initial begin
    logic [7:0] pl[$];
    // Payload ending inside the header.
    pl = '{8'h00, 8'hFF, 8'h00};
    queue_payload(pl);
    // Header, group tag, empty name, a value byte, a name byte, oversize value length.
    pl.delete();
    repeat (ipp_dec_pkg::HEADER_BYTES) pl.push_back((pl.size() % 2) ? 8'h5A : 8'hA5);
    pl.push_back(ipp_dec_pkg::TAG_GROUP_LO);
    pl = {pl, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    pl = {pl, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h37};
    queue_payload(pl);
    while (payload_beats.size() < TARGET_BEATS) add_random_payload();
    beats_total = payload_beats.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (beats_taken < beats_total || decoded_beats.size() > 0);
    repeat (10) @(negedge clk);

    $display("Covered %0d payloads, %0d input beats and %0d result beats:",
             payload_count, beats_taken, results_seen);
    $display("%0d end tags, %0d aborts, %0d payloads ended without an end tag.",
             endtags_seen, aborts_seen, ended_seen);
    if (errors == 0 && decoded_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", decoded_beats.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
sv/ipp_dec_pkg.sv
sv/ipp_attribute_stream_decoder_top.sv
tb/ipp_attribute_stream_decoder_top_tb.sv
